/* sv/gca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_pkg
// Shared types and constants for the grid coarsening accumulator.
// ----------------------------------------------------------------------------
package gca_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF = 16;

    localparam int MASS_IN_BITS   = 32;   // per-cell mass, unsigned Q16.16
    localparam int MASS_BITS      = 48;   // mass accumulator
    localparam int SUM_BITS       = 64;   // component accumulators
    localparam int SCALE_BITS     = 24;   // unsigned Q8.16 scale
    localparam int SCALE_RESET    = 8192; // one eighth
    localparam int BOX_HIGH_RESET = 32767;
    localparam int CHUNK_BITS     = 32;   // shared multiplier operand width
    localparam int PROD_BITS      = 96;   // 64 x 32 product
    localparam int CFG_ADDR_BITS  = 3;
    localparam int FRAC_BITS      = 16;
    localparam int DIV_STEPS      = SUM_BITS + 1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_BOX_LOW_X  = 3'd0,
        REG_BOX_LOW_Y  = 3'd1,
        REG_BOX_LOW_Z  = 3'd2,
        REG_BOX_HIGH_X = 3'd3,
        REG_BOX_HIGH_Y = 3'd4,
        REG_BOX_HIGH_Z = 3'd5,
        REG_MODE       = 3'd6,
        REG_SCALE      = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PTERM,
        S_MUL,
        S_WTERM,
        S_ADD,
        S_MASS,
        S_CHECK,
        S_PMUL,
        S_PRND,
        S_DPREP,
        S_DIV,
        S_DRND,
        S_EMIT
    } state_t;

endpackage

/* sv/grid_coarsen_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_coarsen_accumulator
// Block-average restriction of fine cells into one coarse cell value.
// ----------------------------------------------------------------------------
// Fine cells come in one transfer at a time; the block is busy (s_axis_tready
// low) while it works on a cell, all arithmetic going through one shared
// 32x32 multiplier, one 64-bit saturating adder and a one-bit-per-cycle
// divider under a small sequencer. A cell outside the box is only checked
// for the end of its group. An included cell is added as it is in plain mode
// and takes two multiplier passes per component in weighted mode. The last
// cell of a group adds a scaling multiply and rounding per component in
// plain mode, or one run of the 65-step restoring divider per component in
// weighted mode; a weighted group with zero mass skips the divider.
// The result sits in an output register, so the next cell can be taken
// while it waits; a new result waits only if the previous one is still held.
// ----------------------------------------------------------------------------
module grid_coarsen_accumulator #(
    parameter int VALUE_BITS = gca_pkg::VALUE_BITS_DEF,
    parameter int INDEX_BITS = gca_pkg::INDEX_BITS_DEF,
    localparam int IN_RAW    = 3 * INDEX_BITS + 3 * VALUE_BITS + gca_pkg::MASS_IN_BITS,
    localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW   = 3 * VALUE_BITS,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8,
    localparam int CFG_W     = (INDEX_BITS > gca_pkg::SCALE_BITS) ?
                               INDEX_BITS : gca_pkg::SCALE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [gca_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_W-1:0]                  cfg_data,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // fine_x, fine_y, fine_z, value_a, value_b, value_c, cell_mass
    input  logic [IN_W-1:0]                   s_axis_tdata,
    input  logic                              s_axis_tlast,  // last_of_cell

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_a, result_b, result_c
    output logic [OUT_W-1:0]                  m_axis_tdata,
    output logic                              m_axis_tuser   // empty_mass
);

    localparam int SB  = gca_pkg::SUM_BITS;
    localparam int MB  = gca_pkg::MASS_BITS;
    localparam int MIB = gca_pkg::MASS_IN_BITS;
    localparam int CB  = gca_pkg::CHUNK_BITS;
    localparam int PB  = gca_pkg::PROD_BITS;
    localparam int FB  = gca_pkg::FRAC_BITS;
    localparam int DS  = gca_pkg::DIV_STEPS;
    localparam int DCW = $clog2(DS);

    localparam int OFS_Y = INDEX_BITS;
    localparam int OFS_Z = 2 * INDEX_BITS;
    localparam int OFS_V = 3 * INDEX_BITS;
    localparam int OFS_M = 3 * INDEX_BITS + 3 * VALUE_BITS;

    localparam logic [INDEX_BITS-1:0] HIGH_RESET = (INDEX_BITS > 16) ?
        INDEX_BITS'(gca_pkg::BOX_HIGH_RESET) : {1'b0, {(INDEX_BITS-1){1'b1}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [INDEX_BITS-1:0]      low_x_reg, low_y_reg, low_z_reg;
    logic signed [INDEX_BITS-1:0]      high_x_reg, high_y_reg, high_z_reg;
    logic                              mode_reg;
    logic [gca_pkg::SCALE_BITS-1:0]    scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            low_z_reg  <= '0;
            high_x_reg <= HIGH_RESET;
            high_y_reg <= HIGH_RESET;
            high_z_reg <= HIGH_RESET;
            mode_reg   <= 1'b0;
            scale_reg  <= gca_pkg::SCALE_BITS'(gca_pkg::SCALE_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gca_pkg::REG_BOX_LOW_X:  low_x_reg  <= cfg_data[INDEX_BITS-1:0];
                gca_pkg::REG_BOX_LOW_Y:  low_y_reg  <= cfg_data[INDEX_BITS-1:0];
                gca_pkg::REG_BOX_LOW_Z:  low_z_reg  <= cfg_data[INDEX_BITS-1:0];
                gca_pkg::REG_BOX_HIGH_X: high_x_reg <= cfg_data[INDEX_BITS-1:0];
                gca_pkg::REG_BOX_HIGH_Y: high_y_reg <= cfg_data[INDEX_BITS-1:0];
                gca_pkg::REG_BOX_HIGH_Z: high_z_reg <= cfg_data[INDEX_BITS-1:0];
                gca_pkg::REG_MODE:       mode_reg   <= cfg_data[0];
                gca_pkg::REG_SCALE:      scale_reg  <= cfg_data[gca_pkg::SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a,
                                              input logic [SB-1:0] b);
        logic [SB:0] s;
        s = {a[SB-1], a} + {b[SB-1], b};
        if (s[SB] != s[SB-1])
            return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        return s[SB-1:0];
    endfunction

    // sign and magnitude to a saturated VALUE_BITS field
    function automatic logic [VALUE_BITS-1:0] clamp_out(input logic neg,
                                                        input logic [PB-1:0] mag);
        logic [PB-1:0] lim;
        logic [PB-1:0] r;
        lim = PB'(1) << (VALUE_BITS - 1);
        if (neg)
        begin
            r = (mag > lim) ? lim : mag;
            r = PB'(0) - r;
        end
        else
            r = (mag >= lim) ? (lim - PB'(1)) : mag;
        return r[VALUE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    gca_pkg::state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] val_reg [3];
    logic [MIB-1:0]        mass_in_reg;
    logic                  last_reg;
    logic                  inside_reg;

    logic [SB-1:0]         sum_reg [3];
    logic [MB-1:0]         mass_total_reg;

    logic [1:0]            comp_reg;
    logic [1:0]            phase_reg;
    logic [2*CB-1:0]       mul_reg;
    logic [PB-1:0]         prod_reg;
    logic [SB-1:0]         term_reg;
    logic [DS-1:0]         div_reg;
    logic [MB-1:0]         rem_reg;
    logic [DCW-1:0]        div_cnt_reg;

    logic [VALUE_BITS-1:0] res_reg [3];
    logic                  empty_reg;

    logic [OUT_RAW-1:0]    out_data_reg;
    logic                  out_empty_reg;
    logic                  out_valid_reg;

    // ------------------------------------------------------------------
    // input unpack and box test
    // ------------------------------------------------------------------
    logic signed [INDEX_BITS-1:0] fine_x, fine_y, fine_z;
    logic                         inside_in;

    assign fine_x = s_axis_tdata[INDEX_BITS-1:0];
    assign fine_y = s_axis_tdata[OFS_Y +: INDEX_BITS];
    assign fine_z = s_axis_tdata[OFS_Z +: INDEX_BITS];

    assign inside_in = (fine_x >= low_x_reg) && (fine_y >= low_y_reg) &&
                       (fine_z >= low_z_reg) && (fine_x <= high_x_reg) &&
                       (fine_y <= high_y_reg) && (fine_z <= high_z_reg);

    // ------------------------------------------------------------------
    // shared operand selection
    // ------------------------------------------------------------------
    logic [SB-1:0]   sum_cur, sum_mag, val_ext, val_mag, mul_a;
    logic [CB-1:0]   mul_chunk, mul_b;
    logic            last_comp;
    logic            sum_neg, val_neg;
    logic [PB-1:0]   rnd_mag;
    logic [MB:0]     mass_sum;
    logic [MB:0]     div_trial;
    logic            div_ge;
    logic            div_done;

    assign sum_cur   = sum_reg[comp_reg];
    assign sum_neg   = sum_cur[SB-1];
    assign sum_mag   = sum_neg ? (SB'(0) - sum_cur) : sum_cur;
    assign val_ext   = {{(SB-VALUE_BITS){val_reg[comp_reg][VALUE_BITS-1]}},
                        val_reg[comp_reg]};
    assign val_neg   = val_ext[SB-1];
    assign val_mag   = val_neg ? (SB'(0) - val_ext) : val_ext;
    assign last_comp = (comp_reg == 2'd2);

    assign mul_a     = (state_reg == gca_pkg::S_PMUL) ? sum_mag : val_mag;
    assign mul_b     = (state_reg == gca_pkg::S_PMUL) ? CB'(scale_reg) : mass_in_reg;
    assign mul_chunk = (phase_reg == 2'd0) ? mul_a[CB-1:0] : mul_a[2*CB-1:CB];

    // round half away from zero on the magnitude, then drop the fraction
    assign rnd_mag   = (prod_reg + (PB'(1) << (FB - 1))) >> FB;
    assign mass_sum  = {1'b0, mass_total_reg} + (MB+1)'(mass_in_reg);

    assign div_trial = {rem_reg, div_reg[DS-1]};
    assign div_ge    = (div_trial >= {1'b0, mass_total_reg});
    assign div_done  = (div_cnt_reg == DCW'(DS - 1));

    // ------------------------------------------------------------------
    // sequencer outputs
    // ------------------------------------------------------------------
    logic out_load;

    always_comb
    begin
        s_axis_tready = (state_reg == gca_pkg::S_IDLE);
        out_load      = (state_reg == gca_pkg::S_EMIT) &&
                        (!out_valid_reg || m_axis_tready);
    end

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gca_pkg::S_IDLE:
                if (s_axis_tvalid)
                    state_next = gca_pkg::S_LOAD;
            gca_pkg::S_LOAD:
                if (!inside_reg)
                    state_next = gca_pkg::S_CHECK;
                else if (mode_reg)
                    state_next = gca_pkg::S_MUL;
                else
                    state_next = gca_pkg::S_PTERM;
            gca_pkg::S_PTERM:
                state_next = gca_pkg::S_ADD;
            gca_pkg::S_MUL:
                if (phase_reg == 2'd2)
                    state_next = gca_pkg::S_WTERM;
            gca_pkg::S_WTERM:
                state_next = gca_pkg::S_ADD;
            gca_pkg::S_ADD:
                if (last_comp)
                    state_next = gca_pkg::S_MASS;
                else if (mode_reg)
                    state_next = gca_pkg::S_MUL;
                else
                    state_next = gca_pkg::S_PTERM;
            gca_pkg::S_MASS:
                state_next = gca_pkg::S_CHECK;
            gca_pkg::S_CHECK:
                if (!last_reg)
                    state_next = gca_pkg::S_IDLE;
                else if (!mode_reg)
                    state_next = gca_pkg::S_PMUL;
                else if (mass_total_reg == '0)
                    state_next = gca_pkg::S_EMIT;
                else
                    state_next = gca_pkg::S_DPREP;
            gca_pkg::S_PMUL:
                if (phase_reg == 2'd2)
                    state_next = gca_pkg::S_PRND;
            gca_pkg::S_PRND:
                state_next = last_comp ? gca_pkg::S_EMIT : gca_pkg::S_PMUL;
            gca_pkg::S_DPREP:
                state_next = gca_pkg::S_DIV;
            gca_pkg::S_DIV:
                if (div_done)
                    state_next = gca_pkg::S_DRND;
            gca_pkg::S_DRND:
                state_next = last_comp ? gca_pkg::S_EMIT : gca_pkg::S_DPREP;
            gca_pkg::S_EMIT:
                if (out_load)
                    state_next = gca_pkg::S_IDLE;
            default:
                state_next = gca_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gca_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // control counters and accumulators
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg       <= '0;
            phase_reg      <= '0;
            div_cnt_reg    <= '0;
            sum_reg[0]     <= '0;
            sum_reg[1]     <= '0;
            sum_reg[2]     <= '0;
            mass_total_reg <= '0;
        end
        else
        begin
            case (state_reg)
                gca_pkg::S_LOAD:
                begin
                    comp_reg  <= '0;
                    phase_reg <= '0;
                end
                gca_pkg::S_MUL, gca_pkg::S_PMUL:
                    phase_reg <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                gca_pkg::S_ADD:
                begin
                    sum_reg[comp_reg] <= sat_add(sum_cur, term_reg);
                    comp_reg          <= comp_reg + 2'd1;
                end
                gca_pkg::S_MASS:
                    mass_total_reg <= mass_sum[MB] ? {MB{1'b1}} : mass_sum[MB-1:0];
                gca_pkg::S_CHECK:
                begin
                    comp_reg  <= '0;
                    phase_reg <= '0;
                end
                gca_pkg::S_PRND, gca_pkg::S_DRND:
                    comp_reg <= comp_reg + 2'd1;
                gca_pkg::S_DPREP:
                    div_cnt_reg <= '0;
                gca_pkg::S_DIV:
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                gca_pkg::S_EMIT:
                    if (out_load)
                    begin
                        sum_reg[0]     <= '0;
                        sum_reg[1]     <= '0;
                        sum_reg[2]     <= '0;
                        mass_total_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gca_pkg::S_IDLE:
                if (s_axis_tvalid)
                begin
                    val_reg[0]  <= s_axis_tdata[OFS_V +: VALUE_BITS];
                    val_reg[1]  <= s_axis_tdata[OFS_V + VALUE_BITS +: VALUE_BITS];
                    val_reg[2]  <= s_axis_tdata[OFS_V + 2 * VALUE_BITS +: VALUE_BITS];
                    mass_in_reg <= s_axis_tdata[OFS_M +: MIB];
                    last_reg    <= s_axis_tlast;
                    inside_reg  <= inside_in;
                end
            gca_pkg::S_PTERM:
                term_reg <= val_ext;
            gca_pkg::S_MUL, gca_pkg::S_PMUL:
            begin
                // low chunk, then high chunk; the sum is built from the registered chunk products
                mul_reg <= mul_chunk * mul_b;
                if (phase_reg == 2'd1)
                    prod_reg <= PB'(mul_reg);
                else if (phase_reg == 2'd2)
                    prod_reg <= prod_reg + {mul_reg, {CB{1'b0}}};
            end
            gca_pkg::S_WTERM:
                if (val_neg)
                    term_reg <= (prod_reg >= (PB'(1) << (SB - 1))) ?
                                {1'b1, {(SB-1){1'b0}}} : (SB'(0) - prod_reg[SB-1:0]);
                else
                    term_reg <= (prod_reg[PB-1:SB-1] != '0) ?
                                {1'b0, {(SB-1){1'b1}}} : prod_reg[SB-1:0];
            gca_pkg::S_CHECK:
            begin
                empty_reg  <= mode_reg && (mass_total_reg == '0);
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
            end
            gca_pkg::S_PRND:
                res_reg[comp_reg] <= clamp_out(sum_neg, rnd_mag);
            gca_pkg::S_DPREP:
            begin
                div_reg <= {1'b0, sum_mag} + DS'(mass_total_reg >> 1);
                rem_reg <= '0;
            end
            gca_pkg::S_DIV:
            begin
                rem_reg <= div_ge ? MB'(div_trial - {1'b0, mass_total_reg}) :
                                    div_trial[MB-1:0];
                div_reg <= {div_reg[DS-2:0], div_ge};
            end
            gca_pkg::S_DRND:
                res_reg[comp_reg] <= clamp_out(sum_neg, PB'(div_reg));
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg  <= {res_reg[2], res_reg[1], res_reg[0]};
            out_empty_reg <= empty_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign m_axis_tuser  = out_empty_reg;

`ifndef ASSERT_OFF
    // one cell at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a cell was in progress");

    // restoring divider keeps the partial remainder below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gca_pkg::S_DIV) |-> (rem_reg < mass_total_reg))
        else $error("divider remainder out of range");

    a_div_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gca_pkg::S_DIV) |-> (div_cnt_reg <= DCW'(DS - 1)))
        else $error("divider step count overrun");

    // sums are cleared once the group result is handed to the output
    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum_reg[0] == '0) && (sum_reg[1] == '0) &&
                     (sum_reg[2] == '0) && (mass_total_reg == '0))
        else $error("accumulators not cleared after result");

    a_empty_only_weighted: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && empty_reg |-> mode_reg && (mass_total_reg == '0))
        else $error("empty mass flag without zero weighted mass");
`endif

endmodule
